### design/vn_pkg.sv
// vn_pkg: shared types and constants for the vector normalizer
// no dependencies
`default_nettype none

package vn_pkg;

   localparam int unsigned NUM_COMP       = 4;
   localparam int unsigned UNIT_FRAC_BITS = 14;
   localparam int unsigned QUO_WIDTH      = UNIT_FRAC_BITS + 1;
   localparam int unsigned UNIT_WIDTH     = 16;
   localparam int unsigned MAG_WIDTH      = 17;
   localparam logic [MAG_WIDTH-1:0] MAG_MAX = {MAG_WIDTH{1'b1}};

   // control that travels alongside each vector through the chain
   typedef struct packed {
      logic                valid;
      logic                zero;
      logic [NUM_COMP-1:0] neg;
   } vn_ctrl_type;

endpackage

`default_nettype wire

### design/vn_front.sv
// vn_front: absolute values, squares, sum of squares and per-lane targets
// depends on vn_pkg
`default_nettype none

module vn_front #(
   parameter int unsigned CW = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic [CW-1:0]         comp_i [4],
   output vn_pkg::vn_ctrl_type        ctrl_o,
   output logic      [2*CW:0]         sum_o,
   output logic      [2*CW+27:0]      target_o [4]
);
   import vn_pkg::*;

   localparam int unsigned SW = 2 * CW + 1;
   localparam int unsigned TW = 2 * CW + 28;

   logic                valid_a_ff, valid_b_ff, valid_c_ff;
   logic [NUM_COMP-1:0] neg_a_ff, neg_b_ff, neg_c_ff;
   logic [CW-1:0]       abs_a_ff [4];
   logic [2*CW-1:0]     sq_b_ff [4];
   logic [SW-1:0]       sum_c_ff, sum_c_in;
   logic [TW-1:0]       tgt_c_ff [4];
   logic [CW-1:0]       abs_in [4];

   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         abs_in[i] = comp_i[i][CW-1] ? CW'(-comp_i[i]) : comp_i[i];
      end
      sum_c_in = SW'(sq_b_ff[0]) + SW'(sq_b_ff[1]) + SW'(sq_b_ff[2]) + SW'(sq_b_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= take;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_COMP; i++) begin
         neg_a_ff[i] <= comp_i[i][CW-1];
         abs_a_ff[i] <= abs_in[i];
         sq_b_ff[i]  <= (2 * CW)'(abs_a_ff[i]) * (2 * CW)'(abs_a_ff[i]);
         // a squared scaled by two to the 28th, compared against q squared times sum
         tgt_c_ff[i] <= TW'(sq_b_ff[i]) << (2 * UNIT_FRAC_BITS);
      end
      neg_b_ff <= neg_a_ff;
      neg_c_ff <= neg_b_ff;
      sum_c_ff <= sum_c_in;
   end

   assign ctrl_o.valid = valid_c_ff;
   assign ctrl_o.zero  = (sum_c_ff == '0);
   assign ctrl_o.neg   = neg_c_ff;
   assign sum_o        = sum_c_ff;
   assign target_o     = tgt_c_ff;

endmodule

`default_nettype wire

### design/vn_cell.sv
// vn_cell: one bit step of the square root and of the four unit quotients
// depends on vn_pkg
`default_nettype none

module vn_cell #(
   parameter int unsigned CW  = 16,
   parameter int unsigned BIT = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  vn_pkg::vn_ctrl_type        ctrl_i,
   input  wire logic [2*CW:0]         sum_i,
   input  wire logic [2*CW:0]         srem_i,
   input  wire logic [CW:0]           root_i,
   input  wire logic [2*CW+27:0]      urem_i [4],
   input  wire logic [2*CW+15:0]      uqs_i [4],
   input  wire logic [14:0]           quo_i [4],
   output vn_pkg::vn_ctrl_type        ctrl_o,
   output logic      [2*CW:0]         sum_o,
   output logic      [2*CW:0]         srem_o,
   output logic      [CW:0]           root_o,
   output logic      [2*CW+27:0]      urem_o [4],
   output logic      [2*CW+15:0]      uqs_o [4],
   output logic      [14:0]           quo_o [4]
);
   import vn_pkg::*;

   localparam int unsigned SW   = 2 * CW + 1;
   localparam int unsigned SXW  = 2 * CW + 3;
   localparam int unsigned RW   = CW + 1;
   localparam int unsigned TW   = 2 * CW + 28;
   localparam int unsigned QSW  = 2 * CW + 16;
   localparam int unsigned XW   = 2 * CW + 32;
   localparam bit          SQ_ON = (BIT <= CW);
   localparam bit          UN_ON = (BIT <= UNIT_FRAC_BITS);

   vn_ctrl_type     ctrl_ff;
   logic [SW-1:0]   sum_ff;
   logic [SW-1:0]   srem_ff, srem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [TW-1:0]   urem_ff [4], urem_in [4];
   logic [QSW-1:0]  uqs_ff [4], uqs_in [4];
   logic [14:0]     quo_ff [4], quo_in [4];
   logic [SXW-1:0]  sd;
   logic [XW-1:0]   ud [4];

   always_comb begin
      srem_in = srem_i;
      root_in = root_i;
      urem_in = urem_i;
      uqs_in  = uqs_i;
      quo_in  = quo_i;
      sd      = '0;
      // remainder form: candidate adds 2^(b+1)*r + 2^(2b)
      if (SQ_ON) begin
         sd = (SXW'(root_i) << (BIT + 1)) + (SXW'(1) << (2 * BIT));
         if (sd <= SXW'(srem_i)) begin
            srem_in = SW'(SXW'(srem_i) - sd);
            root_in = root_i | (RW'(1) << BIT);
         end
      end
      for (int i = 0; i < NUM_COMP; i++) begin
         ud[i] = '0;
         // candidate adds 2^(b+1)*q*S + 2^(2b)*S to q squared times S
         if (UN_ON) begin
            ud[i] = (XW'(uqs_i[i]) << (BIT + 1)) + (XW'(sum_i) << (2 * BIT));
            if (ud[i] <= XW'(urem_i[i])) begin
               urem_in[i] = TW'(XW'(urem_i[i]) - ud[i]);
               uqs_in[i]  = QSW'(uqs_i[i] + (QSW'(sum_i) << BIT));
               quo_in[i]  = quo_i[i] | (QUO_WIDTH'(1) << BIT);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_i;
      srem_ff <= srem_in;
      root_ff <= root_in;
      urem_ff <= urem_in;
      uqs_ff  <= uqs_in;
      quo_ff  <= quo_in;
   end

   assign ctrl_o = ctrl_ff;
   assign sum_o  = sum_ff;
   assign srem_o = srem_ff;
   assign root_o = root_ff;
   assign urem_o = urem_ff;
   assign uqs_o  = uqs_ff;
   assign quo_o  = quo_ff;

endmodule

`default_nettype wire

### design/vec4_normalize.sv
// vec4_normalize: top level, length and unit vector of a four-component vector
// depends on vn_pkg, vn_front, vn_cell
//
// usage: drive req_comp_* and pulse start; a transfer happens on any edge with
// start high and busy low. busy is always low, so one vector may enter every
// cycle. components are signed fixed point, COMPONENT_WIDTH bits (Q8.8 at 16).
// each vector yields one result: rsp_valid is high for exactly one cycle with
// rsp_unit_* (signed Q2.14, rounded toward zero), rsp_magnitude (floor of the
// length, saturating at 17 bits) and rsp_zero_vector.
// the path is three front stages (abs, square, sum), one cell per result bit
// in the bit-serial chain, and an output register. throughput is one vector
// per cycle; results leave in arrival order.
// the receiver cannot stall, so the chain never holds back.
// reset clears the valid flags in every stage; vectors in flight are dropped.
`default_nettype none

module vec4_normalize #(
   parameter int unsigned COMPONENT_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_comp_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_comp_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_comp_z,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_comp_w,
   output logic                               rsp_valid,
   output logic signed [15:0]                 rsp_unit_x,
   output logic signed [15:0]                 rsp_unit_y,
   output logic signed [15:0]                 rsp_unit_z,
   output logic signed [15:0]                 rsp_unit_w,
   output logic        [16:0]                 rsp_magnitude,
   output logic                               rsp_zero_vector
);
   import vn_pkg::*;

   localparam int unsigned CW  = COMPONENT_WIDTH;
   localparam int unsigned SW  = 2 * CW + 1;
   localparam int unsigned RW  = CW + 1;
   localparam int unsigned TW  = 2 * CW + 28;
   localparam int unsigned QSW = 2 * CW + 16;
   localparam int unsigned TOP = (CW > UNIT_FRAC_BITS) ? CW : UNIT_FRAC_BITS;
   localparam int unsigned NC  = TOP + 1;
   localparam int unsigned LAT = NC + 4;

   logic [CW-1:0]   comp [4];
   vn_ctrl_type     ctrl [NC+1];
   logic [SW-1:0]   sum  [NC+1];
   logic [SW-1:0]   srem [NC+1];
   logic [RW-1:0]   root [NC+1];
   logic [TW-1:0]   urem [NC+1][4];
   logic [QSW-1:0]  uqs  [NC+1][4];
   logic [14:0]     quo  [NC+1][4];

   logic                  valid_ff;
   logic [UNIT_WIDTH-1:0] unit_ff [4], unit_in [4];
   logic [MAG_WIDTH-1:0]  mag_ff, mag_in;
   logic                  zero_ff;

   assign busy    = 1'b0;
   assign comp[0] = req_comp_x;
   assign comp[1] = req_comp_y;
   assign comp[2] = req_comp_z;
   assign comp[3] = req_comp_w;

   vn_front #(.CW(CW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (start && !busy),
      .comp_i   (comp),
      .ctrl_o   (ctrl[0]),
      .sum_o    (sum[0]),
      .target_o (urem[0])
   );

   assign srem[0] = sum[0];
   assign root[0] = '0;
   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         uqs[0][i] = '0;
         quo[0][i] = '0;
      end
   end

   for (genvar k = 0; k < NC; k++) begin : g_cell
      vn_cell #(.CW(CW), .BIT(TOP - k)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl_i (ctrl[k]),
         .sum_i  (sum[k]),
         .srem_i (srem[k]),
         .root_i (root[k]),
         .urem_i (urem[k]),
         .uqs_i  (uqs[k]),
         .quo_i  (quo[k]),
         .ctrl_o (ctrl[k+1]),
         .sum_o  (sum[k+1]),
         .srem_o (srem[k+1]),
         .root_o (root[k+1]),
         .urem_o (urem[k+1]),
         .uqs_o  (uqs[k+1]),
         .quo_o  (quo[k+1])
      );
   end

   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         if (ctrl[NC].zero) begin
            unit_in[i] = '0;
         end else if (ctrl[NC].neg[i]) begin
            unit_in[i] = UNIT_WIDTH'(-UNIT_WIDTH'(quo[NC][i]));
         end else begin
            unit_in[i] = UNIT_WIDTH'(quo[NC][i]);
         end
      end
      if ((RW + MAG_WIDTH)'(root[NC]) > (RW + MAG_WIDTH)'(MAG_MAX)) begin
         mag_in = MAG_MAX;
      end else begin
         mag_in = MAG_WIDTH'(root[NC]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl[NC].valid;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      mag_ff  <= mag_in;
      zero_ff <= ctrl[NC].zero;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_unit_x      = unit_ff[0];
   assign rsp_unit_y      = unit_ff[1];
   assign rsp_unit_z      = unit_ff[2];
   assign rsp_unit_w      = unit_ff[3];
   assign rsp_magnitude   = mag_ff;
   assign rsp_zero_vector = zero_ff;

`ifndef NO_ASSERTIONS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid)
      else $error("transfer did not produce a result after the pipeline latency");

   a_zero_out : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> rsp_magnitude == '0 && rsp_unit_x == '0 &&
      rsp_unit_y == '0 && rsp_unit_z == '0 && rsp_unit_w == '0)
      else $error("zero vector result carries nonzero fields");

   a_nonzero_len : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_vector |-> rsp_magnitude != '0)
      else $error("nonzero vector gave zero length");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_unit_x <= 16'sd16384 && rsp_unit_x >= -16'sd16384)
      else $error("unit component out of range");
`endif

endmodule

`default_nettype wire

### tb/sv/vec4_normalize_test.sv
// vec4_normalize_test: self-checking bench for the four-component normalizer
// depends on vn_pkg and vec4_normalize; predicts length and unit vector exactly
`timescale 1ns / 100ps

module vec4_normalize_test;
   import vn_pkg::*;

   localparam int CW = 16;
   localparam int LATENCY = CW + 5;

   typedef struct packed {
      logic signed [CW-1:0] x, y, z, w;
   } vec_type;

   typedef struct packed {
      logic signed [15:0] ux, uy, uz, uw;
      logic [MAG_WIDTH-1:0] mag;
      logic zero;
   } norm_type;

   typedef struct {
      vec_type v;
      bit typed;
      norm_type exp;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic signed [CW-1:0] req_comp_x = '0, req_comp_y = '0, req_comp_z = '0, req_comp_w = '0;
   wire busy, rsp_valid, rsp_zero_vector;
   wire signed [15:0] rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_unit_w;
   wire [16:0] rsp_magnitude;

   norm_type pending_norms[$];
   int errors = 0;
   int results_seen = 0;
   int zeros_seen = 0;

   vec4_normalize #(.COMPONENT_WIDTH(CW)) dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("vec4_normalize_test failed");
      $finish;
   end

   // floor of the square root of a sum of squares (fits 33 bits)
   function automatic longint unsigned isqrt(longint unsigned s);
      longint unsigned r, c;
      r = 0;
      for (int b = 17; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= s) r = c;
      end
      return r;
   endfunction

   // largest q with q*q*s <= (a << 14)^2, i.e. trunc(a*2^14/sqrt(s))
   function automatic logic signed [15:0] unit_comp(logic signed [CW-1:0] c,
                                                    longint unsigned s);
      logic [127:0] tgt, p;
      longint unsigned a, q, t;
      a = c < 0 ? -longint'(c) : longint'(c);
      tgt = (128'(a) * a) << 28;
      q = 0;
      for (int b = 14; b >= 0; b--) begin
         t = q | (64'd1 << b);
         p = 128'(t) * t * s;
         if (p <= tgt) q = t;
      end
      return c < 0 ? -16'(q) : 16'(q);
   endfunction

   function automatic norm_type normalize(vec_type v);
      norm_type r;
      longint unsigned s, len;
      s = longint'(v.x) * v.x + longint'(v.y) * v.y + longint'(v.z) * v.z
        + longint'(v.w) * v.w;
      r = '0;
      if (s == 0) begin
         r.zero = 1;
         return r;
      end
      r.ux = unit_comp(v.x, s);
      r.uy = unit_comp(v.y, s);
      r.uz = unit_comp(v.z, s);
      r.uw = unit_comp(v.w, s);
      len = isqrt(s);
      r.mag = len > MAG_MAX ? MAG_MAX : len[MAG_WIDTH-1:0];
      return r;
   endfunction

   task automatic check_field(string name, longint e, longint a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      norm_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_norms.size() == 0) begin
            $error("result with no vector outstanding");
            errors++;
         end else begin
            e = pending_norms.pop_front();
            if (e.zero) zeros_seen++;
            check_field("unit_x", e.ux, rsp_unit_x);
            check_field("unit_y", e.uy, rsp_unit_y);
            check_field("unit_z", e.uz, rsp_unit_z);
            check_field("unit_w", e.uw, rsp_unit_w);
            check_field("magnitude", e.mag, rsp_magnitude);
            check_field("zero_vector", e.zero, rsp_zero_vector);
         end
      end
   end

   // one transfer; the expectation is queued at the accepting edge
   task automatic send(vec_type v, norm_type e);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
            : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_comp_x <= v.x;
      req_comp_y <= v.y;
      req_comp_z <= v.z;
      req_comp_w <= v.w;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_norms.push_back(e);
   endtask

   function automatic logic signed [CW-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return CW'($urandom_range(0, 15)) - 8;
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         2: return '0;
         default: return CW'($urandom);
      endcase
   endfunction

   initial begin
      row_type rows[$];
      row_type r;
      vec_type v;
      int waited;
      // directed rows: exp only where it reads off directly
      r.typed = 1; r.v = '0; r.exp = '0; r.exp.zero = 1; rows.push_back(r);
      r.typed = 1; r.v = '{16'sh0100, 0, 0, 0};
      r.exp = '{16384, 0, 0, 0, 256, 0}; rows.push_back(r);
      r.v = '{0, -16'sh0100, 0, 0}; r.exp = '{0, -16384, 0, 0, 256, 0}; rows.push_back(r);
      r.v = '{0, 0, 16'sh7fff, 0}; r.exp = '{0, 0, 16384, 0, 32767, 0}; rows.push_back(r);
      r.v = '{0, 0, 0, 16'sh8000}; r.exp = '{0, 0, 0, -16384, 32768, 0}; rows.push_back(r);
      r.v = '{16'sh0001, 0, 0, 0}; r.exp = '{16384, 0, 0, 0, 1, 0}; rows.push_back(r);
      r.v = '{16'shffff, 0, 0, 0}; r.exp = '{-16384, 0, 0, 0, 1, 0}; rows.push_back(r);
      r.typed = 0;
      r.v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}; rows.push_back(r);
      r.v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}; rows.push_back(r);
      r.v = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}; rows.push_back(r);
      r.v = '{1, 1, 1, 1}; rows.push_back(r);
      r.v = '{-1, 2, -3, 4}; rows.push_back(r);
      r.v = '{16'sh0300, 16'sh0400, 0, 0}; rows.push_back(r);
      r.v = '{16'sh5555, -16'sh2aaa, 16'sh1234, -16'sh0001}; rows.push_back(r);
      r.v = '{1, 16'sh8000, 0, 0}; rows.push_back(r);

      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i])
         send(rows[i].v, rows[i].typed ? rows[i].exp : normalize(rows[i].v));
      for (int n = 0; n < 700; n++) begin
         v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp(); v.w = rand_comp();
         send(v, normalize(v));
      end
      start <= 0;
      waited = 0;
      while (pending_norms.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 5) @(posedge clock);
      if (pending_norms.size() != 0) begin
         $error("%0d results never arrived", pending_norms.size());
         errors++;
      end
      $display("covered %0d vectors, %0d of them zero", results_seen, zeros_seen);
      if (errors == 0)
         $display("vec4_normalize_test passed");
      else
         $display("vec4_normalize_test failed");
      $finish;
   end

endmodule

### vec4_normalize.f
design/vn_pkg.sv
design/vn_front.sv
design/vn_cell.sv
design/vec4_normalize.sv
tb/sv/vec4_normalize_test.sv
